@@ hdl/ascon80pq_aead_engine_macros.svh @@
// ----------------------------------------------------------------------------
// Ascon-80pq AEAD engine assertion macros
// Concurrent assertion shorthands shared by the checker files.
// ----------------------------------------------------------------------------
`ifndef ASCON80PQ_AEAD_ENGINE_MACROS_SVH
`define ASCON80PQ_AEAD_ENGINE_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASC80_AST_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define ASC80_AST_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/asc80_pkg.sv @@
// ----------------------------------------------------------------------------
// asc80_pkg
// Types, constants and helper functions of the Ascon-80pq AEAD engine.
// ----------------------------------------------------------------------------
`default_nettype none

package asc80_pkg;

	typedef logic [63:0] lane_t;
	typedef lane_t [4:0] state_t;

	localparam lane_t      ASCON_IV  = 64'ha0400c0600000000;
	localparam int         NUM_RND   = 12;
	localparam logic [3:0] FIRST_P12 = 4'd0;
	localparam logic [3:0] FIRST_P6  = 4'd6;
	localparam logic [3:0] LAST_RND  = 4'(NUM_RND - 1);
	localparam logic [3:0] FULL_BLK  = 4'd8;

	localparam int         ADDR_W       = 6;
	localparam logic [2:0] REG_KEY_TOP  = 3'd0;
	localparam logic [2:0] REG_KEY_MID  = 3'd1;
	localparam logic [2:0] REG_KEY_LOW  = 3'd2;
	localparam logic [2:0] REG_NONCE_HI = 3'd3;
	localparam logic [2:0] REG_NONCE_LO = 3'd4;
	localparam logic [2:0] REG_DECRYPT  = 3'd5;

	function automatic lane_t byte_mask(input logic [3:0] n);
		lane_t m;
		m = '0;
		for (int i = 0; i < 8; i++) begin
			if (4'(i) < n)
				m[63 - 8*i -: 8] = 8'hff;
		end
		return m;
	endfunction

	function automatic lane_t pad_bit(input logic [2:0] k);
		lane_t p;
		p = '0;
		for (int i = 0; i < 8; i++) begin
			if (3'(i) == k)
				p[63 - 8*i -: 8] = 8'h80;
		end
		return p;
	endfunction

	function automatic logic [7:0] round_const(input logic [3:0] r);
		return {4'hf - r, r};
	endfunction

endpackage

`default_nettype wire

@@ hdl/asc80_if.sv @@
// ----------------------------------------------------------------------------
// asc80 channel interfaces
// Valid/ready channels for input items and result items of the engine.
// ----------------------------------------------------------------------------
`default_nettype none

interface asc80_in_if;
	logic                valid;
	logic                ready;
	logic                cmd;
	asc80_pkg::lane_t    block_data;
	logic [3:0]          valid_bytes;
	asc80_pkg::lane_t    expected_tag_high;
	asc80_pkg::lane_t    expected_tag_low;

	modport source (
		output valid, cmd, block_data, valid_bytes, expected_tag_high, expected_tag_low,
		input  ready
	);
	modport sink (
		input  valid, cmd, block_data, valid_bytes, expected_tag_high, expected_tag_low,
		output ready
	);
endinterface

interface asc80_out_if;
	logic                valid;
	logic                ready;
	asc80_pkg::lane_t    text_out;
	logic [3:0]          text_bytes;
	asc80_pkg::lane_t    tag_high;
	asc80_pkg::lane_t    tag_low;
	logic                tag_match;
	logic                is_last;

	modport source (
		output valid, text_out, text_bytes, tag_high, tag_low, tag_match, is_last,
		input  ready
	);
	modport sink (
		input  valid, text_out, text_bytes, tag_high, tag_low, tag_match, is_last,
		output ready
	);
endinterface

`default_nettype wire

@@ hdl/asc80_round.sv @@
// ----------------------------------------------------------------------------
// asc80_round
// One Ascon permutation round: constant addition, S-box layer, linear layer.
// ----------------------------------------------------------------------------
`default_nettype none

module asc80_round (
	input  asc80_pkg::state_t s_in,
	input  logic [3:0]        rnd,
	output asc80_pkg::state_t s_out
);

	asc80_pkg::lane_t x0, x1, x2, x3, x4;
	asc80_pkg::lane_t t0, t1, t2, t3, t4;

	always_comb begin
		x0 = s_in[0];
		x1 = s_in[1];
		x2 = s_in[2] ^ {56'd0, asc80_pkg::round_const(rnd)};
		x3 = s_in[3];
		x4 = s_in[4];

		x0 = x0 ^ x4;
		x4 = x4 ^ x3;
		x2 = x2 ^ x1;
		t0 = ~x0 & x1;
		t1 = ~x1 & x2;
		t2 = ~x2 & x3;
		t3 = ~x3 & x4;
		t4 = ~x4 & x0;
		x0 = x0 ^ t1;
		x1 = x1 ^ t2;
		x2 = x2 ^ t3;
		x3 = x3 ^ t4;
		x4 = x4 ^ t0;
		x1 = x1 ^ x0;
		x0 = x0 ^ x4;
		x3 = x3 ^ x2;
		x2 = ~x2;

		s_out[0] = x0 ^ {x0[18:0], x0[63:19]} ^ {x0[27:0], x0[63:28]};
		s_out[1] = x1 ^ {x1[60:0], x1[63:61]} ^ {x1[38:0], x1[63:39]};
		s_out[2] = x2 ^ {x2[0],    x2[63:1]}  ^ {x2[5:0],  x2[63:6]};
		s_out[3] = x3 ^ {x3[9:0],  x3[63:10]} ^ {x3[16:0], x3[63:17]};
		s_out[4] = x4 ^ {x4[6:0],  x4[63:7]}  ^ {x4[40:0], x4[63:41]};
	end

endmodule

`default_nettype wire

@@ hdl/ascon80pq_aead_engine.sv @@
// ----------------------------------------------------------------------------
// ascon80pq_aead_engine
// Ascon-80pq authenticated encryption/decryption over 64-bit blocks.
// ----------------------------------------------------------------------------
//  channel   dir   handshake          payload
//  in_ch     in    valid/ready        cmd, block_data, valid_bytes, expected tags
//  out_ch    out   valid/ready        text_out, text_bytes, tags, tag_match, is_last
//  apb       in    psel/penable       64-bit registers at byte address 8*index
//
//  One round of the shared round unit per cycle; one item at a time.
//  AD block or full text block: accept, then absorb + 6 rounds.
//  First item after idle: 12 init rounds first (key fold on the last one);
//  first text item with no AD: an extra absorb step; text after full AD: padding absorb + 6 rounds.
//  Final text block: absorb + 12 rounds; the result carries the tag.
//  Results sit in an output register; a stalled sink holds the engine only
//  when a second result is ready. Reset clears control state and the key, nonce and mode registers only.
// ----------------------------------------------------------------------------
`default_nettype none

module ascon80pq_aead_engine (
	input  logic                           clk,
	input  logic                           arst_n,
	asc80_in_if.sink                       in_ch,
	asc80_out_if.source                    out_ch,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [asc80_pkg::ADDR_W-1:0]   paddr,
	input  logic [63:0]                    pwdata,
	output logic [63:0]                    prdata,
	output logic                           pready
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_ABSORB = 2'd1;
	localparam logic [1:0] ST_ROUND  = 2'd2;
	localparam logic [1:0] ST_EMIT   = 2'd3;

	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_FRESH = 2'd1;
	localparam logic [1:0] PH_AD    = 2'd2;
	localparam logic [1:0] PH_TEXT  = 2'd3;

	localparam logic [2:0] POST_INIT   = 3'd0;
	localparam logic [2:0] POST_AD     = 3'd1;
	localparam logic [2:0] POST_ADLAST = 3'd2;
	localparam logic [2:0] POST_ADPAD  = 3'd3;
	localparam logic [2:0] POST_TEXT   = 3'd4;
	localparam logic [2:0] POST_FINAL  = 3'd5;

	logic [31:0]       key_top_q;
	asc80_pkg::lane_t  key_mid_q, key_low_q, nonce_hi_q, nonce_lo_q;
	logic              decrypt_q;

	logic [1:0]        st_q, st_d;
	logic [1:0]        phase_q, phase_d;
	logic [2:0]        post_q, post_d;
	logic [3:0]        rnd_q, rnd_d;
	asc80_pkg::state_t lanes_q, lanes_d, round_out;

	logic              cmd_q;
	asc80_pkg::lane_t  data_q, mask_q, exp_hi_q, exp_lo_q;
	logic [3:0]        n_q;
	asc80_pkg::lane_t  text_q, text_d;

	logic              in_acc, slot_free, emit, cfg_wr, fin_last;
	logic [3:0]        n_in;
	logic [2:0]        cfg_idx;
	asc80_pkg::lane_t  mask_in, l0_tmp;

	asc80_round u_round (
		.s_in  (lanes_q),
		.rnd   (rnd_q),
		.s_out (round_out)
	);

	assign cfg_idx = paddr[asc80_pkg::ADDR_W-1:3];
	assign cfg_wr  = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_top_q  <= '0;
			key_mid_q  <= '0;
			key_low_q  <= '0;
			nonce_hi_q <= '0;
			nonce_lo_q <= '0;
			decrypt_q  <= 1'b0;
		end else if (cfg_wr) begin
			case (cfg_idx)
				asc80_pkg::REG_KEY_TOP:  key_top_q  <= pwdata[31:0];
				asc80_pkg::REG_KEY_MID:  key_mid_q  <= pwdata;
				asc80_pkg::REG_KEY_LOW:  key_low_q  <= pwdata;
				asc80_pkg::REG_NONCE_HI: nonce_hi_q <= pwdata;
				asc80_pkg::REG_NONCE_LO: nonce_lo_q <= pwdata;
				asc80_pkg::REG_DECRYPT:  decrypt_q  <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			asc80_pkg::REG_KEY_TOP:  prdata = {32'd0, key_top_q};
			asc80_pkg::REG_KEY_MID:  prdata = key_mid_q;
			asc80_pkg::REG_KEY_LOW:  prdata = key_low_q;
			asc80_pkg::REG_NONCE_HI: prdata = nonce_hi_q;
			asc80_pkg::REG_NONCE_LO: prdata = nonce_lo_q;
			asc80_pkg::REG_DECRYPT:  prdata = {63'd0, decrypt_q};
			default:                 prdata = '0;
		endcase
	end

	assign in_ch.ready = (st_q == ST_IDLE);
	assign in_acc      = in_ch.valid && in_ch.ready;
	assign n_in        = in_ch.valid_bytes[3] ? asc80_pkg::FULL_BLK : in_ch.valid_bytes;
	assign mask_in     = asc80_pkg::byte_mask(n_in);
	assign slot_free   = !out_ch.valid || out_ch.ready;
	assign fin_last    = (rnd_q == asc80_pkg::LAST_RND);

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q    <= in_ch.cmd;
			data_q   <= in_ch.block_data & mask_in;
			mask_q   <= mask_in;
			n_q      <= n_in;
			exp_hi_q <= in_ch.expected_tag_high;
			exp_lo_q <= in_ch.expected_tag_low;
		end
	end

	always_comb begin
		st_d    = st_q;
		phase_d = phase_q;
		post_d  = post_q;
		rnd_d   = rnd_q;
		lanes_d = lanes_q;
		text_d  = text_q;
		emit    = 1'b0;
		l0_tmp  = lanes_q[0];
		case (st_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (phase_q == PH_IDLE) begin
						lanes_d[0] = asc80_pkg::ASCON_IV | {32'd0, key_top_q};
						lanes_d[1] = key_mid_q;
						lanes_d[2] = key_low_q;
						lanes_d[3] = nonce_hi_q;
						lanes_d[4] = nonce_lo_q;
						rnd_d      = asc80_pkg::FIRST_P12;
						post_d     = POST_INIT;
						st_d       = ST_ROUND;
					end else begin
						st_d = ST_ABSORB;
					end
				end
			end
			ST_ABSORB: begin
				if (!cmd_q) begin
					if (phase_q == PH_TEXT) begin
						st_d = ST_IDLE;
					end else begin
						lanes_d[0] = lanes_q[0] ^ data_q;
						rnd_d      = asc80_pkg::FIRST_P6;
						st_d       = ST_ROUND;
						if (n_q != asc80_pkg::FULL_BLK) begin
							lanes_d[0] = lanes_d[0] ^ asc80_pkg::pad_bit(n_q[2:0]);
							post_d     = POST_ADLAST;
						end else begin
							post_d = POST_AD;
						end
					end
				end else begin
					case (phase_q)
						PH_AD: begin
							lanes_d[0] = lanes_q[0] ^ asc80_pkg::pad_bit(3'd0);
							rnd_d      = asc80_pkg::FIRST_P6;
							post_d     = POST_ADPAD;
							st_d       = ST_ROUND;
						end
						PH_TEXT: begin
							if (decrypt_q) begin
								text_d = (lanes_q[0] ^ data_q) & mask_q;
								l0_tmp = (lanes_q[0] & ~mask_q) | data_q;
							end else begin
								l0_tmp = lanes_q[0] ^ data_q;
								text_d = l0_tmp & mask_q;
							end
							st_d = ST_ROUND;
							if (n_q != asc80_pkg::FULL_BLK) begin
								lanes_d[0] = l0_tmp ^ asc80_pkg::pad_bit(n_q[2:0]);
								lanes_d[1] = lanes_q[1] ^ {key_top_q, key_mid_q[63:32]};
								lanes_d[2] = lanes_q[2] ^ {key_mid_q[31:0], key_low_q[63:32]};
								lanes_d[3] = lanes_q[3] ^ {key_low_q[31:0], 32'd0};
								rnd_d      = asc80_pkg::FIRST_P12;
								post_d     = POST_FINAL;
							end else begin
								lanes_d[0] = l0_tmp;
								rnd_d      = asc80_pkg::FIRST_P6;
								post_d     = POST_TEXT;
							end
						end
						default: begin
							lanes_d[4] = lanes_q[4] ^ 64'd1;
							phase_d    = PH_TEXT;
						end
					endcase
				end
			end
			ST_ROUND: begin
				lanes_d = round_out;
				rnd_d   = rnd_q + 4'd1;
				if (fin_last) begin
					case (post_q)
						POST_INIT: begin
							lanes_d[2] = round_out[2] ^ {32'd0, key_top_q};
							lanes_d[3] = round_out[3] ^ key_mid_q;
							lanes_d[4] = round_out[4] ^ key_low_q;
							phase_d    = PH_FRESH;
							st_d       = ST_ABSORB;
						end
						POST_AD: begin
							phase_d = PH_AD;
							st_d    = ST_IDLE;
						end
						POST_ADLAST: begin
							lanes_d[4] = round_out[4] ^ 64'd1;
							phase_d    = PH_TEXT;
							st_d       = ST_IDLE;
						end
						POST_ADPAD: begin
							lanes_d[4] = round_out[4] ^ 64'd1;
							phase_d    = PH_TEXT;
							st_d       = ST_ABSORB;
						end
						POST_TEXT: begin
							emit = slot_free;
							st_d = slot_free ? ST_IDLE : ST_EMIT;
						end
						POST_FINAL: begin
							lanes_d[3] = round_out[3] ^ key_mid_q;
							lanes_d[4] = round_out[4] ^ key_low_q;
							phase_d    = PH_IDLE;
							emit       = slot_free;
							st_d       = slot_free ? ST_IDLE : ST_EMIT;
						end
						default: st_d = ST_IDLE;
					endcase
				end
			end
			ST_EMIT: begin
				emit = slot_free;
				if (slot_free)
					st_d = ST_IDLE;
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			phase_q <= PH_IDLE;
			post_q  <= POST_INIT;
			rnd_q   <= '0;
		end else begin
			st_q    <= st_d;
			phase_q <= phase_d;
			post_q  <= post_d;
			rnd_q   <= rnd_d;
		end
	end

	always_ff @(posedge clk) begin
		lanes_q <= lanes_d;
		text_q  <= text_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_ch.valid <= 1'b0;
		else if (emit)
			out_ch.valid <= 1'b1;
		else if (out_ch.ready)
			out_ch.valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_ch.text_out   <= text_q;
			out_ch.text_bytes <= n_q;
			out_ch.is_last    <= !n_q[3];
			out_ch.tag_high   <= n_q[3] ? '0 : lanes_d[3];
			out_ch.tag_low    <= n_q[3] ? '0 : lanes_d[4];
			out_ch.tag_match  <= !n_q[3] && decrypt_q
				&& (lanes_d[3] == exp_hi_q) && (lanes_d[4] == exp_lo_q);
		end
	end

endmodule

`default_nettype wire

@@ hdl/asc80_chk.sv @@
// ----------------------------------------------------------------------------
// asc80_chk
// Port-level checks of the Ascon-80pq AEAD engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ascon80pq_aead_engine_macros.svh"

module asc80_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [63:0] text_out,
	input logic [3:0]  text_bytes,
	input logic [63:0] tag_high,
	input logic [63:0] tag_low,
	input logic        tag_match,
	input logic        is_last
);

	`ASC80_AST_NXT(a_busy_after_item, clk, arst_n, in_valid && in_ready, !in_ready, "engine ready right after an item")
	`ASC80_AST_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(text_out) && $stable(is_last), "stalled result changed")
	`ASC80_AST_IMP(a_last_short, clk, arst_n, out_valid, is_last == (text_bytes != 4'd8), "is_last disagrees with byte count")
	`ASC80_AST_IMP(a_tag_zero, clk, arst_n, out_valid && !is_last, tag_high == 64'd0 && tag_low == 64'd0 && !tag_match, "tag fields set on non-final result")

endmodule

bind ascon80pq_aead_engine asc80_chk u_asc80_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_ch.valid),
	.in_ready   (in_ch.ready),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.text_out   (out_ch.text_out),
	.text_bytes (out_ch.text_bytes),
	.tag_high   (out_ch.tag_high),
	.tag_low    (out_ch.tag_low),
	.tag_match  (out_ch.tag_match),
	.is_last    (out_ch.is_last)
);

`default_nettype wire

@@ test/ascon80pq_aead_engine_tb_pkg.sv @@
// ----------------------------------------------------------------------------
// Ascon-80pq AEAD engine testbench codes
// Item command and direction codes shared by the checker and the testbench top.
// ----------------------------------------------------------------------------
package ascon80pq_aead_engine_tb_pkg;

	localparam logic CMD_AD       = 1'b0;
	localparam logic CMD_TEXT     = 1'b1;

	localparam logic MODE_ENCRYPT = 1'b0;
	localparam logic MODE_DECRYPT = 1'b1;

endpackage

@@ test/ascon80pq_aead_engine_checker.sv @@
// ----------------------------------------------------------------------------
// Ascon-80pq AEAD engine checker
// Snoops register writes and both channels, runs its own sponge model on every
// accepted item and compares each result item in order, field by field.
// ----------------------------------------------------------------------------
module ascon80pq_aead_engine_checker
	import asc80_pkg::*;
	import ascon80pq_aead_engine_tb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	asc80_in_if               in_ch,
	asc80_out_if              out_ch,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [63:0]       pwdata,
	output int unsigned       fail_count,
	output int unsigned       outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef enum logic [1:0] {MSG_IDLE, MSG_FRESH, MSG_AD, MSG_TEXT} msg_phase_e;

	typedef struct packed {
		lane_t      text;
		logic [3:0] nbytes;
		lane_t      tag_hi;
		lane_t      tag_lo;
		logic       match;
		logic       last;
	} text_result_t;

	lane_t        st [5];
	msg_phase_e   ph;
	lane_t        k_top, k_mid, k_low, n_hi, n_lo;
	logic         dec;
	text_result_t text_q [$];

	function automatic lane_t ror64(input lane_t v, input int n);
		return (v >> n) | (v << (64 - n));
	endfunction

	function automatic lane_t keep_mask(input int n);
		if (n == 0)
			return '0;
		if (n >= 8)
			return '1;
		return {64{1'b1}} << (64 - 8 * n);
	endfunction

	function automatic lane_t pad_byte(input int n);
		return 64'h80 << (56 - 8 * (n % 8));
	endfunction

	function automatic void permute_rounds(input int count);
		lane_t x0, x1, x2, x3, x4, t0, t1, t2, t3, t4;
		for (int r = 12 - count; r < 12; r++) begin
			x0 = st[0]; x1 = st[1]; x2 = st[2]; x3 = st[3]; x4 = st[4];
			x2 ^= lane_t'(((15 - r) << 4) | r);
			x0 ^= x4; x4 ^= x3; x2 ^= x1;
			t0 = ~x0 & x1; t1 = ~x1 & x2; t2 = ~x2 & x3; t3 = ~x3 & x4; t4 = ~x4 & x0;
			x0 ^= t1; x1 ^= t2; x2 ^= t3; x3 ^= t4; x4 ^= t0;
			x1 ^= x0; x0 ^= x4; x3 ^= x2; x2 = ~x2;
			st[0] = x0 ^ ror64(x0, 19) ^ ror64(x0, 28);
			st[1] = x1 ^ ror64(x1, 61) ^ ror64(x1, 39);
			st[2] = x2 ^ ror64(x2, 1) ^ ror64(x2, 6);
			st[3] = x3 ^ ror64(x3, 10) ^ ror64(x3, 17);
			st[4] = x4 ^ ror64(x4, 7) ^ ror64(x4, 41);
		end
	endfunction

	function automatic void start_sponge();
		st[0] = ASCON_IV | k_top;
		st[1] = k_mid;
		st[2] = k_low;
		st[3] = n_hi;
		st[4] = n_lo;
		permute_rounds(12);
		st[2] ^= k_top;
		st[3] ^= k_mid;
		st[4] ^= k_low;
	endfunction

	function automatic bit absorb_item(input logic cmd, input lane_t raw, input logic [3:0] vb,
		input lane_t th, input lane_t tl, output text_result_t res);
		int    n;
		lane_t m, data;
		res = '0;
		n = (vb > 4'd8) ? 8 : int'(vb);
		m = keep_mask(n);
		data = raw & m;
		if (ph == MSG_IDLE) begin
			start_sponge();
			ph = MSG_FRESH;
		end
		if (cmd == CMD_AD) begin
			if (ph == MSG_TEXT)
				return 1'b0;
			st[0] ^= data;
			if (n < 8) begin
				st[0] ^= pad_byte(n);
				permute_rounds(6);
				st[4] ^= 64'd1;
				ph = MSG_TEXT;
			end else begin
				permute_rounds(6);
				ph = MSG_AD;
			end
			return 1'b0;
		end
		if (ph == MSG_AD) begin
			st[0] ^= pad_byte(0);
			permute_rounds(6);
		end
		if (ph != MSG_TEXT) begin
			st[4] ^= 64'd1;
			ph = MSG_TEXT;
		end
		if (dec == MODE_DECRYPT) begin
			res.text = (st[0] ^ data) & m;
			st[0] = (st[0] & ~m) | data;
		end else begin
			st[0] ^= data;
			res.text = st[0] & m;
		end
		res.nbytes = 4'(n);
		if (n == 8) begin
			permute_rounds(6);
		end else begin
			st[0] ^= pad_byte(n);
			st[1] ^= (k_top << 32) | (k_mid >> 32);
			st[2] ^= (k_mid << 32) | (k_low >> 32);
			st[3] ^= k_low << 32;
			permute_rounds(12);
			st[3] ^= k_mid;
			st[4] ^= k_low;
			res.tag_hi = st[3];
			res.tag_lo = st[4];
			res.match = (dec == MODE_DECRYPT) && (st[3] == th) && (st[4] == tl);
			res.last = 1'b1;
			ph = MSG_IDLE;
		end
		return 1'b1;
	endfunction

	always @(posedge clk) begin
		text_result_t want;
		text_result_t seen;
		if (!arst_n) begin
			k_top = '0; k_mid = '0; k_low = '0; n_hi = '0; n_lo = '0;
			dec = MODE_ENCRYPT;
			ph = MSG_IDLE;
			text_q.delete();
			fail_count <= 0;
			outstanding <= 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				seen = {out_ch.text_out, out_ch.text_bytes, out_ch.tag_high, out_ch.tag_low,
					out_ch.tag_match, out_ch.is_last};
				if (text_q.size() == 0) begin
					fail_count <= fail_count + 1;
					if (fail_count < 10)
						$display("%0t: unexpected result text=%h n=%0d tag=%h_%h match=%b last=%b",
							$realtime, seen.text, seen.nbytes, seen.tag_hi, seen.tag_lo,
							seen.match, seen.last);
				end else begin
					want = text_q.pop_front();
					if (seen !== want) begin
						fail_count <= fail_count + 1;
						if (fail_count < 10) begin
							$display("%0t: result mismatch", $realtime);
							$display("  exp text=%h n=%0d tag=%h_%h match=%b last=%b",
								want.text, want.nbytes, want.tag_hi, want.tag_lo,
								want.match, want.last);
							$display("  got text=%h n=%0d tag=%h_%h match=%b last=%b",
								seen.text, seen.nbytes, seen.tag_hi, seen.tag_lo,
								seen.match, seen.last);
						end
					end
				end
			end
			if (in_ch.valid && in_ch.ready) begin
				if (absorb_item(in_ch.cmd, in_ch.block_data, in_ch.valid_bytes,
					in_ch.expected_tag_high, in_ch.expected_tag_low, want))
					text_q.push_back(want);
			end
			if (psel && penable && pwrite && pready) begin
				case (paddr[ADDR_W-1:3])
					REG_KEY_TOP:  k_top = {32'd0, pwdata[31:0]};
					REG_KEY_MID:  k_mid = pwdata;
					REG_KEY_LOW:  k_low = pwdata;
					REG_NONCE_HI: n_hi = pwdata;
					REG_NONCE_LO: n_lo = pwdata;
					REG_DECRYPT:  dec = pwdata[0];
					default: ;
				endcase
			end
			outstanding <= text_q.size();
		end
	end

endmodule

@@ test/ascon80pq_aead_engine_tb.sv @@
// ----------------------------------------------------------------------------
// Ascon-80pq AEAD engine testbench
// Drives whole messages (associated data, text, padded final block) under many
// key, nonce and direction settings, reopens sealed messages in decrypt mode
// with good and corrupted tags, and stalls both channels at random.
// ----------------------------------------------------------------------------
module ascon80pq_aead_engine_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import asc80_pkg::*;
	import ascon80pq_aead_engine_tb_pkg::*;

	localparam int PERIOD    = 10;
	localparam int LIMIT     = 1000000;
	localparam int ITEMS     = 1900;
	localparam int SETTLE    = 48;
	localparam int CALM_FROM = 600;
	localparam int CALM_TO   = 1000;

	typedef struct packed {
		logic       cmd;
		lane_t      data;
		logic [3:0] nbytes;
		lane_t      tag_hi;
		lane_t      tag_lo;
	} block_t;

	typedef struct packed {
		lane_t text;
		lane_t tag_hi;
		lane_t tag_lo;
	} sealed_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel, penable, pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [63:0]       pwdata, prdata;
	logic              pready;
	int unsigned       fail_count, outstanding;
	int unsigned       cycles = 0;
	bit                calm;
	logic              cur_mode;
	int                sent;
	block_t            msg_blocks [$];
	sealed_t           sealed_q [$];

	asc80_in_if  in_ch ();
	asc80_out_if out_ch ();

	ascon80pq_aead_engine u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	ascon80pq_aead_engine_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_ch       (in_ch),
		.out_ch      (out_ch),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.pready      (pready),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	always #(PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n && out_ch.valid && out_ch.ready)
			sealed_q.push_back({out_ch.text_out, out_ch.tag_high, out_ch.tag_low});

	function automatic lane_t rnd64();
		return {$urandom, $urandom};
	endfunction

	function automatic lane_t pick_lane();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return rnd64();
		endcase
	endfunction

	function automatic logic [3:0] full_count();
		return ($urandom_range(5) == 0) ? 4'($urandom_range(9, 15)) : FULL_BLK;
	endfunction

	function automatic void add_block(input logic cmd, input lane_t data, input logic [3:0] nb);
		msg_blocks.push_back({cmd, data, nb, rnd64(), rnd64()});
	endfunction

	// build one well-formed message; stray AD after text is not counted
	function automatic int compose_message();
		int counted, n_ad, n_txt;
		msg_blocks.delete();
		counted = 0;
		n_ad = $urandom_range(0, 3);
		for (int i = 0; i < n_ad; i++) begin
			add_block(CMD_AD, rnd64(), full_count());
			counted++;
		end
		if ($urandom_range(2) != 0) begin
			add_block(CMD_AD, rnd64(), 4'($urandom_range(0, 7)));
			counted++;
		end
		n_txt = $urandom_range(0, 4);
		for (int i = 0; i < n_txt; i++) begin
			add_block(CMD_TEXT, rnd64(), full_count());
			counted++;
			if ($urandom_range(9) == 0)
				add_block(CMD_AD, rnd64(), 4'($urandom_range(0, 15)));
		end
		add_block(CMD_TEXT, rnd64(), 4'($urandom_range(0, 7)));
		counted++;
		return counted;
	endfunction

	task automatic reg_write(input logic [2:0] idx, input logic [63:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'({idx, 3'b000});
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_keys(input lane_t kt, input lane_t km, input lane_t kl,
		input lane_t nh, input lane_t nl);
		reg_write(REG_KEY_TOP, {$urandom, kt[31:0]});
		reg_write(REG_KEY_MID, km);
		reg_write(REG_KEY_LOW, kl);
		reg_write(REG_NONCE_HI, nh);
		reg_write(REG_NONCE_LO, nl);
	endtask

	task automatic set_mode(input logic mode);
		reg_write(REG_DECRYPT, {31'($urandom), $urandom, mode});
		cur_mode = mode;
	endtask

	task automatic send_item(input block_t b);
		while (!calm && $urandom_range(99) < 14) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid             <= 1'b1;
		in_ch.cmd               <= b.cmd;
		in_ch.block_data        <= b.data;
		in_ch.valid_bytes       <= b.nbytes;
		in_ch.expected_tag_high <= b.tag_hi;
		in_ch.expected_tag_low  <= b.tag_lo;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	task automatic send_blocks(input block_t blocks [$]);
		foreach (blocks[i])
			send_item(blocks[i]);
	endtask

	// hold the sender until every result is back and the engine is quiet
	task automatic drain();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	// encrypt msg_blocks, then feed the ciphertext and tag back in decrypt mode
	task automatic seal_and_open(input bit flip);
		int     k;
		block_t b;
		block_t opened [$];
		k = sealed_q.size();
		send_blocks(msg_blocks);
		drain();
		set_mode(MODE_DECRYPT);
		foreach (msg_blocks[i]) begin
			b = msg_blocks[i];
			if (b.cmd == CMD_TEXT) begin
				b.data = sealed_q[k].text;
				if (b.nbytes < FULL_BLK) begin
					b.tag_hi = sealed_q[k].tag_hi;
					b.tag_lo = sealed_q[k].tag_lo;
					if (flip) begin
						if ($urandom_range(1) == 0)
							b.tag_hi ^= 64'd1 << $urandom_range(63);
						else
							b.tag_lo ^= 64'd1 << $urandom_range(63);
					end
				end
				k++;
			end
			opened.push_back(b);
		end
		send_blocks(opened);
		drain();
		set_mode(MODE_ENCRYPT);
	endtask

	initial begin
		int n;
		arst_n                  = 1'b0;
		psel                    = 1'b0;
		penable                 = 1'b0;
		pwrite                  = 1'b0;
		paddr                   = '0;
		pwdata                  = '0;
		in_ch.valid             = 1'b0;
		in_ch.cmd               = CMD_AD;
		in_ch.block_data        = '0;
		in_ch.valid_bytes       = '0;
		in_ch.expected_tag_high = '0;
		in_ch.expected_tag_low  = '0;
		out_ch.ready            = 1'b0;
		calm                    = 1'b0;
		cur_mode                = MODE_ENCRYPT;
		sent                    = 0;
		fork
			forever begin
				@(posedge clk);
				out_ch.ready <= calm || ($urandom_range(99) >= 14);
			end
		join_none
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty message under reset register values
		msg_blocks.delete();
		add_block(CMD_TEXT, '1, 4'd0);
		send_blocks(msg_blocks);
		drain();

		// all-ones key and nonce, extreme fields, reopened with good and bad tag
		load_keys('1, '1, '1, '1, '1);
		set_mode(MODE_ENCRYPT);
		msg_blocks.delete();
		add_block(CMD_AD, '1, FULL_BLK);
		add_block(CMD_AD, '1, 4'd0);
		add_block(CMD_TEXT, '1, 4'd15);
		add_block(CMD_TEXT, '1, 4'd7);
		seal_and_open(1'b0);
		seal_and_open(1'b1);

		// full AD only, oversized count, stray AD after text
		load_keys('0, '0, '0, '0, '0);
		msg_blocks.delete();
		add_block(CMD_AD, '0, FULL_BLK);
		add_block(CMD_AD, '1, FULL_BLK);
		add_block(CMD_TEXT, '0, 4'd9);
		add_block(CMD_AD, '1, FULL_BLK);
		add_block(CMD_TEXT, '1, 4'd3);
		send_blocks(msg_blocks);
		drain();

		// decrypt with a tag that cannot match
		set_mode(MODE_DECRYPT);
		msg_blocks.delete();
		add_block(CMD_AD, '1, 4'd5);
		add_block(CMD_TEXT, rnd64(), FULL_BLK);
		add_block(CMD_TEXT, rnd64(), 4'd1);
		send_blocks(msg_blocks);
		drain();
		set_mode(MODE_ENCRYPT);

		while (sent < ITEMS) begin
			calm = (sent >= CALM_FROM) && (sent < CALM_TO);
			if ($urandom_range(2) != 0) begin
				drain();
				load_keys(pick_lane(), pick_lane(), pick_lane(), pick_lane(), pick_lane());
				set_mode(($urandom_range(2) == 0) ? MODE_DECRYPT : MODE_ENCRYPT);
			end
			n = compose_message();
			if (cur_mode == MODE_ENCRYPT && $urandom_range(3) == 0) begin
				drain();
				seal_and_open($urandom_range(2) == 0);
				sent += 2 * n;
			end else begin
				send_blocks(msg_blocks);
				sent += n;
			end
		end
		calm = 1'b0;
		drain();

		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
